/* rtl/shvd_pkg.sv */
// Package for the sync header voice deframer.
// Holds the shared constants, register indexes and the voice word type.
// No dependencies.
`timescale 1ns / 1ps

package shvd_pkg;

  localparam int unsigned HEADER_BYTES_DEF = 8;
  localparam int unsigned VOICE_BYTES_DEF  = 18;

  localparam logic [15:0] SYNC_WORD_RST = 16'hD471;
  localparam logic [1:0]  SYNC_MIN_RST  = 2'd2;
  localparam logic [7:0]  BYTE_MASK     = 8'hFF;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_WORD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_MIN  = 1'b1;

  typedef struct packed {
    logic [7:0]  voice_byte;
    logic [23:0] unit_id;
    logic [7:0]  tg_id;
    logic        first_of_frame;
    logic        last_of_frame;
  } voice_word_t;

endpackage

/* rtl/sync_header_voice_deframer.sv */
// Top level of the sync header voice deframer.
// Instantiates shvd_front, shvd_queue and shvd_back; depends on shvd_pkg.
//
//   Channel | Direction | Handshake             | Word
//   cfg     | in        | cfg_valid_i/ready_o   | cfg_idx_i, cfg_data_i
//   in      | in        | in_valid_i/in_ready_o | in_byte_i
//   out     | out       | out_valid_o/ready_i   | voice byte, ids, frame marks
//
// One received byte is taken every cycle while the two-entry queue has room.
// Each voice word is queued, then moved into the output register.
// Configuration writes are always taken.
// Reset returns the block to sync search with the reset register values.
// A stalled output fills the queue, after which in_ready_o drops.
`timescale 1ns / 1ps

module sync_header_voice_deframer import shvd_pkg::*; #(
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int unsigned VOICE_BYTES  = VOICE_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           voice_byte_o,
  output logic [23:0]          unit_id_o,
  output logic [7:0]           tg_id_o,
  output logic                 first_of_frame_o,
  output logic                 last_of_frame_o
);

  logic        q_full;
  logic        q_empty;
  logic        q_push;
  logic        q_pop;
  voice_word_t push_word;
  voice_word_t pop_word;
  voice_word_t out_word;

  assign cfg_ready_o = 1'b1;

  shvd_front #(
    .HEADER_BYTES(HEADER_BYTES),
    .VOICE_BYTES (VOICE_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .in_ready_o (in_ready_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_word_o   (push_word)
  );

  shvd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_word_i(push_word),
    .pop_i      (q_pop),
    .pop_word_o (pop_word),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  shvd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_word_i   (pop_word),
    .q_pop_o    (q_pop),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_word_o (out_word)
  );

  assign voice_byte_o     = out_word.voice_byte;
  assign unit_id_o        = out_word.unit_id;
  assign tg_id_o          = out_word.tg_id;
  assign first_of_frame_o = out_word.first_of_frame;
  assign last_of_frame_o  = out_word.last_of_frame;

endmodule

/* rtl/shvd_front.sv */
// Front end of the deframer: sync search, header capture and voice tagging.
// Holds the configuration registers. Depends on shvd_pkg.
`timescale 1ns / 1ps

module shvd_front import shvd_pkg::*; #(
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int unsigned VOICE_BYTES  = VOICE_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 in_valid_i,
  input  logic [7:0]           in_byte_i,
  output logic                 in_ready_o,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output voice_word_t          q_word_o
);

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_HEADER,
    PH_VOICE
  } phase_e;

  phase_e      phase_q;
  logic [7:0]  prev_byte_q;
  logic        prev_valid_q;
  logic [7:0]  count_q;
  logic [23:0] unit_id_q;
  logic [7:0]  tg_id_q;
  logic [15:0] sync_word_q;
  logic [1:0]  sync_min_q;

  logic       accept;
  logic [1:0] hits;
  logic       pair_sync;
  logic [8:0] count_inc;
  logic       header_done;
  logic       voice_done;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign hits = {1'b0, prev_byte_q == sync_word_q[15:8]} +
                {1'b0, (in_byte_i & BYTE_MASK) == sync_word_q[7:0]};
  assign pair_sync = (hits == 2'd2) || (hits >= sync_min_q);

  assign count_inc   = {1'b0, count_q} + 9'd1;
  assign header_done = count_inc >= 9'(HEADER_BYTES);
  assign voice_done  = count_inc >= 9'(VOICE_BYTES);

  assign q_push_o = accept && (phase_q == PH_VOICE);

  always_comb begin
    q_word_o.voice_byte     = in_byte_i;
    q_word_o.unit_id        = unit_id_q;
    q_word_o.tg_id          = tg_id_q;
    q_word_o.first_of_frame = (count_q == 8'd0);
    q_word_o.last_of_frame  = voice_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_SEARCH;
      prev_byte_q  <= 8'd0;
      prev_valid_q <= 1'b0;
      count_q      <= 8'd0;
      unit_id_q    <= 24'd0;
      tg_id_q      <= 8'd0;
      sync_word_q  <= SYNC_WORD_RST;
      sync_min_q   <= SYNC_MIN_RST;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_idx_i)
          REG_SYNC_WORD: sync_word_q <= cfg_data_i;
          REG_SYNC_MIN:  sync_min_q  <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (accept) begin
        case (phase_q)
          PH_HEADER: begin
            case (count_q)
              8'd1: unit_id_q[23:16] <= in_byte_i;
              8'd2: unit_id_q[15:8]  <= in_byte_i;
              8'd3: unit_id_q[7:0]   <= in_byte_i;
              8'd4: tg_id_q          <= in_byte_i;
              default: ;
            endcase
            if (header_done) begin
              phase_q <= PH_VOICE;
              count_q <= 8'd0;
            end else begin
              count_q <= count_inc[7:0];
            end
          end
          PH_VOICE: begin
            if (voice_done) begin
              phase_q      <= PH_SEARCH;
              count_q      <= 8'd0;
              prev_valid_q <= 1'b0;
              prev_byte_q  <= 8'd0;
            end else begin
              count_q <= count_inc[7:0];
            end
          end
          default: begin
            if (prev_valid_q && pair_sync) begin
              phase_q      <= PH_HEADER;
              count_q      <= 8'd0;
              prev_valid_q <= 1'b0;
              prev_byte_q  <= 8'd0;
            end else begin
              phase_q      <= PH_SEARCH;
              prev_byte_q  <= in_byte_i;
              prev_valid_q <= 1'b1;
            end
          end
        endcase
      end
    end
  end

endmodule

/* rtl/shvd_queue.sv */
// Short queue of voice words between the front end and the output stage.
// Depends on shvd_pkg.
`timescale 1ns / 1ps

module shvd_queue import shvd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  voice_word_t push_word_i,
  input  logic        pop_i,
  output voice_word_t pop_word_o,
  output logic        full_o,
  output logic        empty_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  voice_word_t         mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q;
  logic [PtrW-1:0]     rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                do_push;
  logic                do_pop;

  assign full_o     = (count_q == CntW'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_word_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

/* rtl/shvd_back.sv */
// Output stage of the deframer: registers one voice word towards the consumer.
// Depends on shvd_pkg.
`timescale 1ns / 1ps

module shvd_back import shvd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  voice_word_t q_word_i,
  output logic        q_pop_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output voice_word_t out_word_o
);

  logic        valid_q;
  voice_word_t word_q;

  assign q_pop_o     = !q_empty_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      valid_q <= !q_empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      word_q <= q_word_i;
    end
  end

endmodule

/* rtl/shvd_checker.sv */
// Port-level checker for the sync header voice deframer, bound to the top level.
// Depends on shvd_pkg and sync_header_voice_deframer.
`timescale 1ns / 1ps

module shvd_checker import shvd_pkg::*; #(
  parameter int unsigned VOICE_BYTES = VOICE_BYTES_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  voice_byte_o,
  input logic        first_of_frame_o,
  input logic        last_of_frame_o
);

  localparam logic SingleByteFrame = (VOICE_BYTES == 1);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(voice_byte_o))
    else $error("Stalled output word was dropped or changed.");

  a_rise_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("Output word appeared without an accepted input byte.");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("Input stalled while the output register was empty.");

  a_first_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && first_of_frame_o |-> last_of_frame_o == SingleByteFrame)
    else $error("Frame marks disagree with the frame length.");

endmodule

bind sync_header_voice_deframer shvd_checker #(
  .VOICE_BYTES(VOICE_BYTES)
) u_shvd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .voice_byte_o    (voice_byte_o),
  .first_of_frame_o(first_of_frame_o),
  .last_of_frame_o (last_of_frame_o)
);

/* bench/shvd_tb_pkg.sv */
// Scoreboard package for the sync header voice deframer testbench.
// Holds a byte-by-byte predictor of the deframer and the queue of expected voice words.
// Depends on shvd_pkg for the register indexes, frame sizes and the voice word type.
`timescale 1ns / 1ps

package shvd_tb_pkg;
  import shvd_pkg::*;

  typedef enum logic [1:0] {HUNT, IN_HEADER, IN_VOICE} frame_phase_e;

  class deframer_scoreboard;
    logic [15:0]  sync_word;
    logic [1:0]   min_matches;
    frame_phase_e phase;
    logic [7:0]   last_byte;
    bit           last_byte_held;
    int           pos;
    logic [23:0]  unit_id;
    logic [7:0]   tg_id;
    voice_word_t  expected_words[$];
    int unsigned  bytes_in;
    int unsigned  words_out;
    int unsigned  frames_seen;
    int unsigned  errors;

    function new();
      sync_word      = SYNC_WORD_RST;
      min_matches    = SYNC_MIN_RST;
      phase          = HUNT;
      last_byte      = '0;
      last_byte_held = 1'b0;
      pos            = 0;
      unit_id        = '0;
      tg_id          = '0;
      bytes_in       = 0;
      words_out      = 0;
      frames_seen    = 0;
      errors         = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
      if (idx == REG_SYNC_WORD) sync_word = data;
      else if (idx == REG_SYNC_MIN) min_matches = data[1:0];
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function bit sync_pair(logic [7:0] first, logic [7:0] second);
      int hits;
      hits = 0;
      if (first == sync_word[15:8]) hits++;
      if (second == sync_word[7:0]) hits++;
      return (hits == 2) || (hits >= min_matches);
    endfunction

    function void note_byte(logic [7:0] b);
      voice_word_t w;
      bytes_in++;
      case (phase)
        IN_HEADER: begin
          case (pos)
            1: unit_id[23:16] = b;
            2: unit_id[15:8] = b;
            3: unit_id[7:0] = b;
            4: tg_id = b;
            default: ;
          endcase
          if (pos + 1 >= HEADER_BYTES_DEF) begin
            phase = IN_VOICE;
            pos = 0;
          end else begin
            pos++;
          end
        end
        IN_VOICE: begin
          w.voice_byte     = b;
          w.unit_id        = unit_id;
          w.tg_id          = tg_id;
          w.first_of_frame = (pos == 0);
          w.last_of_frame  = (pos + 1 >= VOICE_BYTES_DEF);
          expected_words = {expected_words, w};
          if (w.last_of_frame) begin
            phase = HUNT;
            pos = 0;
            last_byte_held = 1'b0;
            last_byte = '0;
            frames_seen++;
          end else begin
            pos++;
          end
        end
        default: begin
          if (last_byte_held && sync_pair(last_byte, b)) begin
            phase = IN_HEADER;
            pos = 0;
            last_byte_held = 1'b0;
            last_byte = '0;
          end else begin
            last_byte = b;
            last_byte_held = 1'b1;
          end
        end
      endcase
    endfunction

    task report(string field, logic [23:0] got, logic [23:0] want);
      errors++;
      if (errors <= 25)
        $display("Mismatch in %s at word %0d: got 0x%0h, expected 0x%0h.",
                 field, words_out, got, want);
    endtask

    task check_word(voice_word_t got);
      voice_word_t want;
      if (expected_words.size() == 0) begin
        report("voice_byte of a word nobody expected", 24'(got.voice_byte), '0);
        return;
      end
      want = expected_words[0];
      expected_words.delete(0);
      if (got.voice_byte !== want.voice_byte)
        report("voice_byte", 24'(got.voice_byte), 24'(want.voice_byte));
      if (got.unit_id !== want.unit_id)
        report("unit_id", got.unit_id, want.unit_id);
      if (got.tg_id !== want.tg_id)
        report("tg_id", 24'(got.tg_id), 24'(want.tg_id));
      if (got.first_of_frame !== want.first_of_frame)
        report("first_of_frame", 24'(got.first_of_frame), 24'(want.first_of_frame));
      if (got.last_of_frame !== want.last_of_frame)
        report("last_of_frame", 24'(got.last_of_frame), 24'(want.last_of_frame));
      words_out++;
    endtask
  endclass

endpackage

/* bench/sync_header_voice_deframer_tb.sv */
// Top-level testbench for sync_header_voice_deframer with directed and random byte streams.
// Drives the configuration and input channels, stalls the output, and checks every voice word.
// Depends on shvd_pkg, shvd_tb_pkg and the deframer RTL.
`timescale 1ns / 1ps

module sync_header_voice_deframer_tb;
  import shvd_pkg::*;
  import shvd_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned CONFIG_STEPS   = 9;
  localparam int unsigned ITEMS_PER_STEP = 85;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_idx      = REG_SYNC_WORD;
  logic [15:0]          cfg_data     = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_byte      = '0;
  logic                 out_valid;
  logic                 out_ready    = 1'b0;
  logic [7:0]           voice_byte;
  logic [23:0]          unit_id;
  logic [7:0]           tg_id;
  logic                 first_of_frame;
  logic                 last_of_frame;

  deframer_scoreboard sb = new();

  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          hold_left     = 0;
  int unsigned cycle_count   = 0;
  logic [15:0] live_word     = SYNC_WORD_RST;

  // A negative entry asks for a random sync word.
  int         word_plan [CONFIG_STEPS] = '{'h0000, 'hFFFF, -1, -1, SYNC_WORD_RST, -1, -1,
                                           'hFFFF, -1};
  logic [1:0] min_plan  [CONFIG_STEPS] = '{2'd2, 2'd3, 2'd1, 2'd0, 2'd2, 2'd1, 2'd3, 2'd0,
                                           2'd2};

  // One full frame under the reset settings, with extreme header and voice values.
  logic [7:0] opening_bytes [29] = '{
    8'hFF, 8'hD4, 8'h71,
    8'h00, 8'hFF, 8'h00, 8'hFF, 8'h5A, 8'hFF, 8'hFF, 8'hFF,
    8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40,
    8'h80, 8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'h7F
  };

  sync_header_voice_deframer dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .in_byte_i        (in_byte),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .voice_byte_o     (voice_byte),
    .unit_id_o        (unit_id),
    .tg_id_o          (tg_id),
    .first_of_frame_o (first_of_frame),
    .last_of_frame_o  (last_of_frame)
  );

  always #5 clk = ~clk;

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b);
  endtask

  task automatic send_frame();
    int kind;
    int voice_len;
    kind = $urandom_range(99);
    if (kind < 80) begin
      repeat ($urandom_range(3)) send_byte(8'($urandom));
      send_byte(live_word[15:8]);
      send_byte(live_word[7:0]);
      repeat (HEADER_BYTES_DEF) send_byte(8'($urandom));
      voice_len = (kind < 72) ? VOICE_BYTES_DEF : $urandom_range(VOICE_BYTES_DEF - 1);
      repeat (voice_len) send_byte(8'($urandom));
    end else if (kind < 90) begin
      send_byte(live_word[15:8]);
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] word_val, input logic [1:0] min_val);
    logic [15:0] min_data;
    min_data  = {14'($urandom), min_val};
    live_word = word_val;
    cfg_valid <= 1'b1;
    cfg_idx   <= REG_SYNC_WORD;
    cfg_data  <= word_val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(REG_SYNC_WORD, word_val);
    cfg_idx  <= REG_SYNC_MIN;
    cfg_data <= min_data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(REG_SYNC_MIN, min_data);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_word(voice_word_t'{voice_byte, unit_id, tg_id, first_of_frame,
                                    last_of_frame});
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped at the limit of %0d cycles.", CYCLE_LIMIT);
    $display("sync_header_voice_deframer_tb: FAIL");
    $finish;
  end

  initial begin
    int unsigned start_count;
    bit          held_off;
    int          stage;
    logic [15:0] word_now;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
    settle();
    for (int setting_no = 0; setting_no < CONFIG_STEPS; setting_no++) begin
      stage = setting_no / 3;
      send_idle_pct = (stage == 0) ? 13 : (stage == 1) ? 81 : 0;
      stall_pct     = (stage == 0) ? 81 : (stage == 1) ? 13 : 0;
      word_now = (word_plan[setting_no] < 0) ? 16'($urandom) : 16'(word_plan[setting_no]);
      set_config(word_now, min_plan[setting_no]);
      start_count = sb.bytes_in;
      held_off = 1'b0;
      while (sb.bytes_in - start_count < ITEMS_PER_STEP) begin
        if (!held_off && sb.bytes_in - start_count >= 40) begin
          hold_left = 48;
          held_off = 1'b1;
        end
        send_frame();
      end
      settle();
    end
    $display("Sent %0d bytes under %0d sync settings; checked %0d voice words, %0d whole frames.",
             sb.bytes_in, CONFIG_STEPS + 1, sb.words_out, sb.frames_seen);
    $display("Sender and receiver idling were varied, with a long output hold-off per setting.");
    if (sb.errors == 0) begin
      $display("sync_header_voice_deframer_tb: PASS");
    end else begin
      $display("sync_header_voice_deframer_tb: FAIL");
    end
    $finish;
  end

endmodule
